/* rtl/grid_region_table_macros.svh */
// Assertion macros shared by the grid region table checker.
`ifndef GRID_REGION_TABLE_MACROS_SVH
`define GRID_REGION_TABLE_MACROS_SVH

// Checked on every clock edge outside reset.
`define GRT_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("grid_region_table check failed");

// Checked on every clock edge, reset included.
`define GRT_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("grid_region_table check failed");

`endif

/* rtl/grt_pkg.sv */
// Shared types and constants of the grid region table.
`default_nettype none
package grt_pkg;

    localparam int MAX_REGIONS = 16;
    localparam int IDX_W       = $clog2(MAX_REGIONS);
    localparam int MAX_GRID    = 64;
    localparam int DIV_W       = 23;

    // Request modes.
    localparam logic [1:0] MODE_ADD    = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_OCC    = 2'd2;
    localparam logic [1:0] MODE_BOUNDS = 2'd3;

    // Register indexes.
    localparam logic [1:0] REG_COLS = 2'd0;
    localparam logic [1:0] REG_ROWS = 2'd1;
    localparam logic [1:0] REG_WINW = 2'd2;
    localparam logic [1:0] REG_WINH = 2'd3;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] scene_id;
        logic [5:0] col;
        logic [5:0] row;
        logic [6:0] span_cols;
        logic [6:0] span_rows;
    } t_in;

    typedef struct packed {
        logic        accepted;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [15:0] size_w;
        logic [15:0] size_h;
    } t_out;

    // Partial result handed from cell to cell during a scan.
    typedef struct packed {
        logic             vld;
        logic             overlap;
        logic             occ;
        logic             hit;
        logic [IDX_W-1:0] hit_idx;
        logic             free;
        logic [IDX_W-1:0] free_idx;
        logic [5:0]       col;
        logic [5:0]       row;
        logic [6:0]       spc;
        logic [6:0]       spr;
    } t_carry;

    // Slot write broadcast to all cells.
    typedef struct packed {
        logic             en;
        logic             clr;
        logic [IDX_W-1:0] idx;
        logic [7:0]       key;
        logic [5:0]       col;
        logic [5:0]       row;
        logic [6:0]       spc;
        logic [6:0]       spr;
    } t_wr;

endpackage
`default_nettype wire

/* rtl/grt_cell.sv */
// One table slot with its stage of the scan chain.
`default_nettype none
module grt_cell (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire  [grt_pkg::IDX_W-1:0]   i_idx,
    input  grt_pkg::t_in                i_req,
    input  grt_pkg::t_wr                i_wr,
    input  grt_pkg::t_carry             i_car,
    output grt_pkg::t_carry             o_car
);
    logic       r_vld;
    logic [7:0] r_key;
    logic [5:0] r_col;
    logic [5:0] r_row;
    logic [6:0] r_spc;
    logic [6:0] r_spr;
    grt_pkg::t_carry r_car;
    grt_pkg::t_carry n_car;

    logic [7:0] a_cend, a_rend, s_cend, s_rend, q_col, q_row, s_col, s_row;
    logic       key_eq, ov_here, occ_here;

    // Local tests of the request against this slot.
    always_comb begin
        q_col  = 8'(i_req.col);
        q_row  = 8'(i_req.row);
        s_col  = 8'(r_col);
        s_row  = 8'(r_row);
        a_cend = q_col + 8'(i_req.span_cols);
        a_rend = q_row + 8'(i_req.span_rows);
        s_cend = s_col + 8'(r_spc);
        s_rend = s_row + 8'(r_spr);
        key_eq = r_vld && (r_key == i_req.scene_id);
        ov_here = r_vld && !key_eq &&
                  !(a_cend <= s_col || q_col >= s_cend ||
                    a_rend <= s_row || q_row >= s_rend);
        occ_here = r_vld && q_col >= s_col && q_col < s_cend &&
                   q_row >= s_row && q_row < s_rend;
    end

    // Merge this slot into the running result.
    always_comb begin
        n_car         = i_car;
        n_car.overlap = i_car.overlap | ov_here;
        n_car.occ     = i_car.occ | occ_here;
        if (key_eq && !i_car.hit) begin
            n_car.hit     = 1'b1;
            n_car.hit_idx = i_idx;
            n_car.col     = r_col;
            n_car.row     = r_row;
            n_car.spc     = r_spc;
            n_car.spr     = r_spr;
        end
        if (!r_vld && !i_car.free) begin
            n_car.free     = 1'b1;
            n_car.free_idx = i_idx;
        end
    end

    // Chain stage register.
    always_ff @(posedge i_clk) begin
        r_car <= n_car;
        if (!i_rst_n) begin
            r_car.vld <= 1'b0;
        end
    end

    // Slot storage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_wr.en && i_wr.idx == i_idx) begin
            r_vld <= !i_wr.clr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en && !i_wr.clr && i_wr.idx == i_idx) begin
            r_key <= i_wr.key;
            r_col <= i_wr.col;
            r_row <= i_wr.row;
            r_spc <= i_wr.spc;
            r_spr <= i_wr.spr;
        end
    end

    assign o_car = r_car;
endmodule
`default_nettype wire

/* rtl/grt_div.sv */
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module grt_div (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_start,
    input  wire  [grt_pkg::DIV_W-1:0] i_num,
    input  wire  [6:0]                i_den,
    output logic                      o_done,
    output logic [grt_pkg::DIV_W-1:0] o_quo
);
    logic [grt_pkg::DIV_W-1:0] r_q;
    logic [6:0]                r_rem;
    logic [6:0]                r_den;
    logic [4:0]                r_cnt;
    logic                      r_done;
    logic [7:0]                trial;

    assign trial = {r_rem, r_q[grt_pkg::DIV_W-1]};

    // Control: bit counter and done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 5'd0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= 5'(grt_pkg::DIV_W);
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == 5'd1);
            if (r_cnt != 5'd0) begin
                r_cnt <= r_cnt - 5'd1;
            end
        end
    end

    // Datapath: shift the dividend out and the quotient in.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= 7'd0;
            r_den <= i_den;
        end else if (r_cnt != 5'd0) begin
            if (trial >= {1'b0, r_den}) begin
                r_rem <= 7'(trial - {1'b0, r_den});
                r_q   <= {r_q[grt_pkg::DIV_W-2:0], 1'b1};
            end else begin
                r_rem <= trial[6:0];
                r_q   <= {r_q[grt_pkg::DIV_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;
endmodule
`default_nettype wire

/* rtl/grid_region_table.sv */
// A request scans a chain of 16 slot cells, one cell per cycle; add and remove then write back.
// Bounds, on a hit, adds a multiply state, a divider start state and a bit-serial division of four values.
// One request at a time: a new one is taken only after the last result is loaded into the output register.
// Synchronous active-low reset empties the table and restores 1x1 grid, zero window.
`default_nettype none
module grid_region_table (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_ready,
    input  grt_pkg::t_in       i_in_data,
    output logic               o_out_valid,
    input  wire                i_out_ready,
    output grt_pkg::t_out      o_out_data,
    input  wire                psel,
    input  wire                penable,
    input  wire                pwrite,
    input  wire  [3:0]         paddr,
    input  wire  [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_DST  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]  r_state, n_state;
    logic [6:0]  r_cols, r_rows;
    logic [15:0] r_winw, r_winh;
    grt_pkg::t_in    r_req;
    logic            r_seed;
    grt_pkg::t_out   r_res, n_res;
    grt_pkg::t_out   r_out;
    logic            r_ovld;
    grt_pkg::t_carry r_hit, n_hit;
    logic [grt_pkg::DIV_W-1:0] r_prod [4];
    grt_pkg::t_carry chain [grt_pkg::MAX_REGIONS+1];
    grt_pkg::t_carry tail;
    grt_pkg::t_wr    wr;
    logic [6:0]  ecols, erows;
    logic        in_acc, cfg_wr, out_load;
    logic        div_done [4];
    logic [grt_pkg::DIV_W-1:0] div_quo [4];
    logic [6:0]  div_den [4];

    function automatic logic [6:0] eff_count(input logic [6:0] v);
        logic [6:0] e;
        if (v == 7'd0) begin
            e = 7'd1;
        end else if (v > 7'(grt_pkg::MAX_GRID)) begin
            e = 7'(grt_pkg::MAX_GRID);
        end else begin
            e = v;
        end
        return e;
    endfunction

    function automatic logic [15:0] sat16(input logic [grt_pkg::DIV_W-1:0] v);
        return (v > grt_pkg::DIV_W'(16'hFFFF)) ? 16'hFFFF : v[15:0];
    endfunction

    assign ecols    = eff_count(r_cols);
    assign erows    = eff_count(r_rows);
    assign in_acc   = i_in_valid && o_in_ready;
    assign cfg_wr   = psel && penable && pwrite;
    assign out_load = (r_state == S_DONE) && (!r_ovld || i_out_ready);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= 7'd1;
            r_rows <= 7'd1;
            r_winw <= 16'd0;
            r_winh <= 16'd0;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                grt_pkg::REG_COLS: r_cols <= pwdata[6:0];
                grt_pkg::REG_ROWS: r_rows <= pwdata[6:0];
                grt_pkg::REG_WINW: r_winw <= pwdata[15:0];
                grt_pkg::REG_WINH: r_winh <= pwdata[15:0];
                default: r_cols <= r_cols;
            endcase
        end
    end

    // Register readback.
    always_comb begin
        case (paddr[3:2])
            grt_pkg::REG_COLS: prdata = 32'(r_cols);
            grt_pkg::REG_ROWS: prdata = 32'(r_rows);
            grt_pkg::REG_WINW: prdata = 32'(r_winw);
            grt_pkg::REG_WINH: prdata = 32'(r_winh);
            default:           prdata = 32'd0;
        endcase
    end
    assign pready = 1'b1;

    // Request capture and scan seed.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_req <= i_in_data;
        end
        if (!i_rst_n) begin
            r_seed <= 1'b0;
        end else begin
            r_seed <= in_acc;
        end
    end

    // Cell chain.
    always_comb begin
        chain[0]     = '0;
        chain[0].vld = r_seed;
    end

    for (genvar g = 0; g < grt_pkg::MAX_REGIONS; g++) begin : g_cell
        grt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (grt_pkg::IDX_W'(g)),
            .i_req   (r_req),
            .i_wr    (wr),
            .i_car   (chain[g]),
            .o_car   (chain[g+1])
        );
    end
    assign tail = chain[grt_pkg::MAX_REGIONS];

    // Decision at the end of the scan.
    always_comb begin
        n_state = r_state;
        n_res   = r_res;
        n_hit   = r_hit;
        wr      = '0;
        wr.key  = r_req.scene_id;
        wr.col  = r_req.col;
        wr.row  = r_req.row;
        wr.spc  = r_req.span_cols;
        wr.spr  = r_req.span_rows;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (tail.vld) begin
                    n_res   = '0;
                    n_state = S_DONE;
                    case (r_req.mode)
                        grt_pkg::MODE_ADD: begin
                            n_res.accepted =
                                (8'(r_req.col) + 8'(r_req.span_cols) <= 8'(ecols)) &&
                                (8'(r_req.row) + 8'(r_req.span_rows) <= 8'(erows)) &&
                                !tail.overlap && (tail.hit || tail.free);
                            wr.en  = n_res.accepted;
                            wr.idx = tail.hit ? tail.hit_idx : tail.free_idx;
                        end
                        grt_pkg::MODE_REMOVE: begin
                            n_res.accepted = tail.hit;
                            wr.en  = tail.hit;
                            wr.clr = 1'b1;
                            wr.idx = tail.hit_idx;
                        end
                        grt_pkg::MODE_OCC: begin
                            n_res.accepted = tail.occ;
                        end
                        default: begin
                            n_res.accepted = tail.hit;
                            n_hit          = tail;
                            if (tail.hit) begin
                                n_state = S_MUL;
                            end
                        end
                    endcase
                end
            end
            S_MUL:  n_state = S_DST;
            S_DST:  n_state = S_DIV;
            S_DIV: begin
                if (div_done[0]) begin
                    n_res.pos_x  = sat16(div_quo[0]);
                    n_res.pos_y  = sat16(div_quo[1]);
                    n_res.size_w = sat16(div_quo[2]);
                    n_res.size_h = sat16(div_quo[3]);
                    n_state      = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        r_hit <= n_hit;
    end

    // Products of cell counts and window size, at full width.
    always_ff @(posedge i_clk) begin
        if (r_state == S_MUL) begin
            r_prod[0] <= grt_pkg::DIV_W'(r_hit.col) * grt_pkg::DIV_W'(r_winw);
            r_prod[1] <= grt_pkg::DIV_W'(r_hit.row) * grt_pkg::DIV_W'(r_winh);
            r_prod[2] <= grt_pkg::DIV_W'(r_hit.spc) * grt_pkg::DIV_W'(r_winw);
            r_prod[3] <= grt_pkg::DIV_W'(r_hit.spr) * grt_pkg::DIV_W'(r_winh);
        end
    end

    assign div_den[0] = ecols;
    assign div_den[1] = erows;
    assign div_den[2] = ecols;
    assign div_den[3] = erows;

    for (genvar d = 0; d < 4; d++) begin : g_div
        grt_div u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (r_state == S_DST),
            .i_num   (r_prod[d]),
            .i_den   (div_den[d]),
            .o_done  (div_done[d]),
            .o_quo   (div_quo[d])
        );
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (out_load) begin
            r_ovld <= 1'b1;
        end else if (i_out_ready) begin
            r_ovld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= r_res;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovld;
    assign o_out_data  = r_out;
endmodule
`default_nettype wire

/* rtl/grt_checker.sv */
// Port-level checks of the grid region table, bound to the top level.
`default_nettype none
`include "grid_region_table_macros.svh"
module grt_checker (
    input wire           i_clk,
    input wire           i_rst_n,
    input wire           i_in_valid,
    input wire           o_in_ready,
    input grt_pkg::t_in  i_in_data,
    input wire           o_out_valid,
    input wire           i_out_ready,
    input grt_pkg::t_out o_out_data,
    input wire           pready
);
    // The APB port never stalls.
    `GRT_ASSERT_ALWAYS(a_pready, pready)
    // A taken request blocks the input until its work completes.
    `GRT_ASSERT(a_one_at_a_time, (i_in_valid && o_in_ready) |=> !o_in_ready)
    // A waiting result holds.
    `GRT_ASSERT(a_out_hold, (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
    // A refused result carries no pixel bounds.
    `GRT_ASSERT(a_zero_bounds, (o_out_valid && !o_out_data.accepted) |-> (o_out_data.pos_x == 16'd0 && o_out_data.pos_y == 16'd0 && o_out_data.size_w == 16'd0 && o_out_data.size_h == 16'd0))
endmodule

bind grid_region_table grt_checker u_grt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data),
    .pready      (pready)
);
`default_nettype wire

/* test/tb_grid_region_table.sv */
// Testbench for the grid region table: random and directed requests checked against a predictor.
`default_nettype none
module tb_grid_region_table;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_SLOTS = grt_pkg::MAX_REGIONS;
    localparam int GRID_CAP  = grt_pkg::MAX_GRID;
    localparam int CYCLE_LIMIT = 2000000;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_in_valid;
    logic          o_in_ready;
    grt_pkg::t_in  i_in_data;
    logic          o_out_valid;
    logic          i_out_ready;
    grt_pkg::t_out o_out_data;
    logic          psel;
    logic          penable;
    logic          pwrite;
    logic [3:0]    paddr;
    logic [31:0]   pwdata;
    logic [31:0]   prdata;
    logic          pready;

    grid_region_table dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Predictor copy of the table and the registers.
    logic       tbl_used [NUM_SLOTS];
    logic [7:0] tbl_key  [NUM_SLOTS];
    logic [5:0] tbl_col  [NUM_SLOTS];
    logic [5:0] tbl_row  [NUM_SLOTS];
    logic [6:0] tbl_spc  [NUM_SLOTS];
    logic [6:0] tbl_spr  [NUM_SLOTS];
    logic [6:0]  cfg_cols;
    logic [6:0]  cfg_rows;
    logic [15:0] cfg_winw;
    logic [15:0] cfg_winh;

    grt_pkg::t_out pending_results[$];
    int   mismatches;
    int   cycles;
    int   send_idle_pct;
    int   recv_stall_pct;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Cycle counter with a hard limit.
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    function automatic int unsigned grid_count(logic [6:0] v);
        if (v == 0) return 1;
        if (v > GRID_CAP) return GRID_CAP;
        return v;
    endfunction

    function automatic logic [15:0] to_pixels(int unsigned cells, int unsigned pix,
                                              int unsigned cnt);
        longint unsigned q;
        q = (longint'(cells) * longint'(pix)) / cnt;
        return (q > 65535) ? 16'hFFFF : q[15:0];
    endfunction

    function automatic int find_key(logic [7:0] k);
        for (int i = 0; i < NUM_SLOTS; i++)
            if (tbl_used[i] && tbl_key[i] == k) return i;
        return -1;
    endfunction

    // Work out the result of one request and update the predicted table.
    function automatic grt_pkg::t_out predict_region_op(grt_pkg::t_in req);
        grt_pkg::t_out res;
        int   s;
        int unsigned c, r, sc, sr;
        logic ok;
        res = '0;
        ok = 1'b0;
        c = req.col; r = req.row; sc = req.span_cols; sr = req.span_rows;
        case (req.mode)
            grt_pkg::MODE_ADD: begin
                ok = 1'b1;
                if (c + sc > grid_count(cfg_cols) || r + sr > grid_count(cfg_rows)) ok = 1'b0;
                for (int i = 0; i < NUM_SLOTS && ok; i++) begin
                    if (!tbl_used[i] || tbl_key[i] == req.scene_id) continue;
                    if (!(c + sc <= tbl_col[i] || c >= tbl_col[i] + tbl_spc[i] ||
                          r + sr <= tbl_row[i] || r >= tbl_row[i] + tbl_spr[i]))
                        ok = 1'b0;
                end
                if (ok) begin
                    s = find_key(req.scene_id);
                    if (s < 0)
                        for (int i = NUM_SLOTS - 1; i >= 0; i--)
                            if (!tbl_used[i]) s = i;
                    if (s < 0) ok = 1'b0;
                    else begin
                        tbl_used[s] = 1'b1; tbl_key[s] = req.scene_id;
                        tbl_col[s] = req.col; tbl_row[s] = req.row;
                        tbl_spc[s] = req.span_cols; tbl_spr[s] = req.span_rows;
                    end
                end
            end
            grt_pkg::MODE_REMOVE: begin
                for (int i = 0; i < NUM_SLOTS; i++)
                    if (tbl_used[i] && tbl_key[i] == req.scene_id) begin
                        tbl_used[i] = 1'b0;
                        ok = 1'b1;
                    end
            end
            grt_pkg::MODE_OCC: begin
                for (int i = 0; i < NUM_SLOTS; i++)
                    if (tbl_used[i] && c >= tbl_col[i] && c < tbl_col[i] + tbl_spc[i] &&
                        r >= tbl_row[i] && r < tbl_row[i] + tbl_spr[i])
                        ok = 1'b1;
            end
            default: begin
                s = find_key(req.scene_id);
                if (s >= 0) begin
                    ok = 1'b1;
                    res.pos_x  = to_pixels(tbl_col[s], cfg_winw, grid_count(cfg_cols));
                    res.pos_y  = to_pixels(tbl_row[s], cfg_winh, grid_count(cfg_rows));
                    res.size_w = to_pixels(tbl_spc[s], cfg_winw, grid_count(cfg_cols));
                    res.size_h = to_pixels(tbl_spr[s], cfg_winh, grid_count(cfg_rows));
                end
            end
        endcase
        res.accepted = ok;
        return res;
    endfunction

    // Send one request; the expectation is queued when it is accepted.
    // Valid drops only when the sender goes idle or the caller drains.
    task automatic send_request(grt_pkg::t_in req);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pending_results.insert(pending_results.size(), predict_region_op(req));
        @(negedge i_clk);
    endtask

    // Stop sending, wait until every result is back, then idle a while.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
    endtask

    // One APB write; the caller releases the bus after the last one.
    task automatic write_register(logic [1:0] idx, logic [31:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            grt_pkg::REG_COLS: cfg_cols = val[6:0];
            grt_pkg::REG_ROWS: cfg_rows = val[6:0];
            grt_pkg::REG_WINW: cfg_winw = val[15:0];
            default:           cfg_winh = val[15:0];
        endcase
        @(negedge i_clk);
    endtask

    task automatic set_grid(int unsigned cols, int unsigned rows,
                            int unsigned ww, int unsigned wh);
        drain_results();
        write_register(grt_pkg::REG_COLS, cols);
        write_register(grt_pkg::REG_ROWS, rows);
        write_register(grt_pkg::REG_WINW, ww);
        write_register(grt_pkg::REG_WINH, wh);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    function automatic grt_pkg::t_in make_req(logic [1:0] m, logic [7:0] id, int unsigned c,
                                              int unsigned r, int unsigned sc,
                                              int unsigned sr);
        grt_pkg::t_in q;
        q.mode = m; q.scene_id = id; q.col = 6'(c); q.row = 6'(r);
        q.span_cols = 7'(sc); q.span_rows = 7'(sr);
        return q;
    endfunction

    // Result checker and receiver stalls.
    always @(posedge i_clk) begin
        grt_pkg::t_out exp_res;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result %p", o_out_data);
            end else begin
                exp_res = pending_results.pop_front();
                if (o_out_data !== exp_res) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Result mismatch: expected %p, got %p", exp_res, o_out_data);
                end
            end
        end
    end

    always @(negedge i_clk)
        i_out_ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);

    // Directed requests at the extremes and every special case.
    task automatic test_directed();
        set_grid(0, 0, 100, 100);
        send_request(make_req(grt_pkg::MODE_ADD, 8'd1, 0, 0, 1, 1));
        send_request(make_req(grt_pkg::MODE_ADD, 8'd2, 0, 0, 1, 2));
        send_request(make_req(grt_pkg::MODE_OCC, 8'd0, 0, 0, 0, 0));
        send_request(make_req(grt_pkg::MODE_BOUNDS, 8'd1, 0, 0, 0, 0));
        set_grid(127, 127, 65535, 65535);
        send_request(make_req(grt_pkg::MODE_ADD, 8'd255, 63, 63, 1, 1));
        send_request(make_req(grt_pkg::MODE_ADD, 8'd3, 0, 0, 64, 64));
        send_request(make_req(grt_pkg::MODE_ADD, 8'd4, 10, 10, 0, 0));
        send_request(make_req(grt_pkg::MODE_ADD, 8'd5, 0, 0, 0, 0));
        send_request(make_req(grt_pkg::MODE_ADD, 8'd1, 2, 2, 3, 3));
        send_request(make_req(grt_pkg::MODE_ADD, 8'd7, 0, 0, 127, 127));
        send_request(make_req(grt_pkg::MODE_BOUNDS, 8'd255, 0, 0, 0, 0));
        send_request(make_req(grt_pkg::MODE_BOUNDS, 8'd9, 0, 0, 0, 0));
        set_grid(4, 4, 1000, 700);
        send_request(make_req(grt_pkg::MODE_BOUNDS, 8'd255, 0, 0, 0, 0));
        send_request(make_req(grt_pkg::MODE_OCC, 8'd0, 63, 63, 0, 0));
        send_request(make_req(grt_pkg::MODE_REMOVE, 8'd1, 0, 0, 0, 0));
        send_request(make_req(grt_pkg::MODE_REMOVE, 8'd1, 0, 0, 0, 0));
        send_request(make_req(grt_pkg::MODE_REMOVE, 8'd255, 0, 0, 0, 0));
        // Fill the table, which still holds two regions, so the last three new keys must be refused.
        set_grid(64, 64, 640, 480);
        for (int i = 0; i < NUM_SLOTS + 1; i++)
            send_request(make_req(grt_pkg::MODE_ADD, 8'(20 + i), i * 3, 0, 2, 2));
        for (int i = 0; i < NUM_SLOTS + 1; i++)
            send_request(make_req(grt_pkg::MODE_REMOVE, 8'(20 + i), 0, 0, 0, 0));
        for (int i = 0; i < 4; i++)
            send_request(make_req(grt_pkg::MODE_REMOVE, 8'(i + 1), 0, 0, 0, 0));
        send_request(make_req(grt_pkg::MODE_REMOVE, 8'd5, 0, 0, 0, 0));
        send_request(make_req(grt_pkg::MODE_REMOVE, 8'd7, 0, 0, 0, 0));
    endtask

    // Random requests: mostly small-key adds and queries on the current grid.
    task automatic test_random(int count);
        grt_pkg::t_in q;
        int unsigned gc, gr;
        for (int n = 0; n < count; n++) begin
            gc = grid_count(cfg_cols);
            gr = grid_count(cfg_rows);
            q.mode = 2'($urandom_range(3));
            q.scene_id = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(23));
            if ($urandom_range(9) == 0) begin
                q.col = 6'($urandom); q.row = 6'($urandom);
                q.span_cols = 7'($urandom); q.span_rows = 7'($urandom);
            end else begin
                q.col = 6'($urandom_range(gc - 1)); q.row = 6'($urandom_range(gr - 1));
                q.span_cols = 7'($urandom_range(gc - q.col > 8 ? 8 : gc - q.col));
                q.span_rows = 7'($urandom_range(gr - q.row > 8 ? 8 : gr - q.row));
            end
            if (q.mode == grt_pkg::MODE_REMOVE && $urandom_range(2) != 0)
                q.mode = grt_pkg::MODE_ADD;
            send_request(q);
        end
    endtask

    task automatic test_idle_phases();
        int sender [4] = '{0, 48, 0, 25};
        int recv   [4] = '{0, 0, 48, 25};
        for (int p = 0; p < 4; p++) begin
            set_grid($urandom_range(127), $urandom_range(127), $urandom, $urandom);
            send_idle_pct = sender[p];
            recv_stall_pct = recv[p];
            test_random(230);
            // Hold off until everything is back, then change the grid under stored regions.
            drain_results();
            set_grid($urandom_range(1, 64), $urandom_range(1, 64), $urandom, $urandom);
            test_random(230);
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    initial begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            tbl_used[i] = 1'b0; tbl_key[i] = '0; tbl_col[i] = '0;
            tbl_row[i] = '0; tbl_spc[i] = '0; tbl_spr[i] = '0;
        end
        cfg_cols = 7'd1; cfg_rows = 7'd1; cfg_winw = '0; cfg_winh = '0;
        mismatches = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_ready = 1'b1;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_idle_phases();
        drain_results();
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
`default_nettype wire

/* grid_region_table.f */
+incdir+rtl
rtl/grt_pkg.sv
rtl/grt_cell.sv
rtl/grt_div.sv
rtl/grid_region_table.sv
rtl/grt_checker.sv
test/tb_grid_region_table.sv
